// File: src/mtd_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the
// multitone I/Q demodulator. No dependencies.
package mtd_pkg;

   localparam int MAX_TONES = 16;
   localparam int DECIM     = 16;
   localparam int MA_LEN    = 16;
   localparam int STAGES    = 4;
   localparam int ROM_BITS  = 12;

   localparam int TONE_W  = $clog2(MAX_TONES);
   localparam int NUM_W   = 5;
   localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int HP_W    = (MA_LEN > 1) ? $clog2(MA_LEN) : 1;
   localparam int DEC_W   = 8;
   localparam int SUM_AW  = TONE_W + 1 + STAGE_W;
   localparam int HIST_AW = SUM_AW + HP_W;
   localparam int HIST_DEPTH = MAX_TONES * 2 * (1 << STAGE_W) * (1 << HP_W);
   localparam int SUM_DEPTH  = MAX_TONES * 2 * (1 << STAGE_W);
   localparam int QUARTER = 1 << (ROM_BITS - 2);
   localparam int ACC_W   = 40;
   localparam int DATA_W  = 56;
   localparam longint ONE30 = 64'sd1 <<< 30;

   localparam logic [1:0] CSR_NUM_TONES  = 2'd0;
   localparam logic [1:0] CSR_FIRST_STEP = 2'd1;
   localparam logic [1:0] CSR_SPACING    = 2'd2;
   localparam logic [1:0] CSR_PERIOD     = 2'd3;

   typedef logic [14:0] qtab_type [QUARTER+1];

   typedef struct packed {
      logic [HIST_AW-1:0] addr;
      logic               we;
      logic [DATA_W-1:0]  hist_wdata;
      logic [DATA_W-1:0]  sum_wdata;
   } ma_ctl_type;

   function automatic logic [14:0] quarter_sine(input int r);
      longint t;
      longint t2;
      longint a;
      longint s;
      longint v;
      t  = longint'(r) <<< (30 - (ROM_BITS - 2));
      t2 = t * t / ONE30;
      a  = -3864;
      a  = 172272 + a * t2 / ONE30;
      a  = -5026995 + a * t2 / ONE30;
      a  = 85569306 + a * t2 / ONE30;
      a  = -693598343 + a * t2 / ONE30;
      a  = 1686629713 + a * t2 / ONE30;
      s  = a * t / ONE30;
      v  = (s * 32767 + (ONE30 / 2)) / ONE30;
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      return v[14:0];
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type tab;
      for (int r = 0; r <= QUARTER; r++) begin
         tab[r] = quarter_sine(r);
      end
      return tab;
   endfunction

endpackage

// File: src/mtd_sine_rom.sv
// Quarter-wave sine table with registered read and sign restore.
// Depends on mtd_pkg.
module mtd_sine_rom (
   input  logic                         clock,
   input  logic [mtd_pkg::ROM_BITS-1:0] rom_addr,
   output logic signed [15:0]           rom_data
);
   import mtd_pkg::*;

   localparam qtab_type QTAB = build_qtab();
   localparam int QI_W = ROM_BITS - 1;

   logic [ROM_BITS-3:0] r;
   logic [QI_W-1:0]     qidx;
   logic [14:0]         data_ff;
   logic                neg_ff;

   assign r    = rom_addr[ROM_BITS-3:0];
   // odd quadrants run the quarter backwards
   assign qidx = rom_addr[ROM_BITS-2] ? (QI_W'(QUARTER) - QI_W'(r)) : QI_W'(r);

   always_ff @(posedge clock) begin
      data_ff <= QTAB[qidx];
      neg_ff  <= rom_addr[ROM_BITS-1];
   end

   assign rom_data = neg_ff ? -$signed({1'b0, data_ff}) : $signed({1'b0, data_ff});
endmodule

// File: src/mtd_ma_mem.sv
// History and running-sum memories of the moving-sum cascade, with a
// clearing pass after reset. Depends on mtd_pkg.
module mtd_ma_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  mtd_pkg::ma_ctl_type         ma_ctl,
   output logic [mtd_pkg::DATA_W-1:0]  hist_rdata,
   output logic [mtd_pkg::DATA_W-1:0]  sum_rdata,
   output logic                        clr_busy
);
   import mtd_pkg::*;

   logic [DATA_W-1:0] hist_mem [HIST_DEPTH];
   logic [DATA_W-1:0] sum_mem  [SUM_DEPTH];
   logic [HIST_AW:0]  clr_cnt_ff;
   logic [HIST_AW:0]  clr_cnt_in;
   logic [SUM_AW-1:0] sum_addr;

   assign clr_busy   = (clr_cnt_ff < (HIST_AW+1)'(HIST_DEPTH));
   assign clr_cnt_in = clr_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign sum_addr   = ma_ctl.addr[HIST_AW-1:HP_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy) begin
         hist_mem[clr_cnt_ff[HIST_AW-1:0]] <= '0;
         if (clr_cnt_ff < (HIST_AW+1)'(SUM_DEPTH)) begin
            sum_mem[clr_cnt_ff[SUM_AW-1:0]] <= '0;
         end
      end else if (ma_ctl.we) begin
         hist_mem[ma_ctl.addr] <= ma_ctl.hist_wdata;
         sum_mem[sum_addr]     <= ma_ctl.sum_wdata;
      end
      hist_rdata <= hist_mem[ma_ctl.addr];
      sum_rdata  <= sum_mem[sum_addr];
   end
endmodule

// File: src/multitone_iq_demod_cic.sv
// Multitone I/Q demodulator with cascaded moving-sum decimator: sequencer,
// shared mixing multiplier and accumulators. Depends on mtd_pkg,
// mtd_sine_rom and mtd_ma_mem.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_sample
//   rsp     | out       | rsp_valid/rsp_stall | tone_index, baseband_i/q, last
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// Each sample runs phase, sine, cosine and two accumulate states per active
// tone: one sine ROM port is read twice per tone and one multiplier serves
// I and Q. Every DECIM-th sample adds, per tone, a read and a write of the
// moving-sum memories for each stage and channel, plus an emit per result.
// After reset a clearing pass over the history memory holds req_stall high.
// A stalled result holds the sequencer in emit with req_stall high; once the
// last result of a block is loaded, samples are taken again while it waits.
module multitone_iq_demod_cic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [15:0]                 req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [3:0]                         rsp_tone_index,
   output logic signed [mtd_pkg::DATA_W-1:0]  rsp_baseband_i,
   output logic signed [mtd_pkg::DATA_W-1:0]  rsp_baseband_q,
   output logic                               rsp_last,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [31:0]                        csr_wdata
);
   import mtd_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PHASE = 4'd1;
   localparam logic [3:0] S_SIN   = 4'd2;
   localparam logic [3:0] S_COS   = 4'd3;
   localparam logic [3:0] S_MQ    = 4'd4;
   localparam logic [3:0] S_MI    = 4'd5;
   localparam logic [3:0] S_FRD   = 4'd6;
   localparam logic [3:0] S_FWR   = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   logic [NUM_W-1:0]  num_tones_ff;
   logic [31:0]       first_step_ff;
   logic [31:0]       spacing_ff;
   logic [15:0]       period_ff;

   logic [3:0]        state_ff;
   logic [15:0]       pos_ff;
   logic [DEC_W-1:0]  decim_ff;
   logic [HP_W-1:0]   hp_ff;
   logic [TONE_W-1:0] tone_ff;
   logic [TONE_W-1:0] nlast_ff;
   logic              chan_ff;
   logic [STAGE_W-1:0] stage_ff;
   logic signed [15:0] sample_ff;
   logic [31:0]       step_ff;
   logic [31:0]       phase_ff;
   logic signed [31:0] mul_ff;
   logic signed [ACC_W-1:0] acc_i_ff [MAX_TONES];
   logic signed [ACC_W-1:0] acc_q_ff [MAX_TONES];
   logic [DATA_W-1:0] x_ff;
   logic [DATA_W-1:0] xi_ff;

   logic              rsp_valid_ff;
   logic [3:0]        rsp_tone_ff;
   logic [DATA_W-1:0] rsp_i_ff;
   logic [DATA_W-1:0] rsp_q_ff;
   logic              rsp_last_ff;

   logic [ROM_BITS-1:0] k;
   logic [ROM_BITS-1:0] rom_addr;
   logic signed [15:0]  rom_data;
   logic signed [31:0]  mix_prod;
   ma_ctl_type          ma_ctl;
   logic [DATA_W-1:0]   hist_rdata;
   logic [DATA_W-1:0]   sum_rdata;
   logic                clr_busy;
   logic [DATA_W-1:0]   x_in;
   logic [DATA_W-1:0]   new_sum;
   logic [NUM_W-1:0]    n_eff;
   logic                req_take;
   logic                emit_go;
   logic                emit_fire;
   logic signed [ACC_W-1:0] acc_sel;

   mtd_sine_rom u_rom (
      .clock    (clock),
      .rom_addr (rom_addr),
      .rom_data (rom_data)
   );

   mtd_ma_mem u_ma (
      .clock      (clock),
      .reset      (reset),
      .ma_ctl     (ma_ctl),
      .hist_rdata (hist_rdata),
      .sum_rdata  (sum_rdata),
      .clr_busy   (clr_busy)
   );

   assign req_stall = clr_busy || (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign emit_go   = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = (state_ff == S_EMIT) && emit_go;

   always_comb begin
      if (num_tones_ff == '0) begin
         n_eff = NUM_W'(1);
      end else if (num_tones_ff > NUM_W'(MAX_TONES)) begin
         n_eff = NUM_W'(MAX_TONES);
      end else begin
         n_eff = num_tones_ff;
      end
   end

   assign k        = phase_ff[31 -: ROM_BITS];
   assign rom_addr = (state_ff == S_COS) ? k + ROM_BITS'(QUARTER) : k;
   assign mix_prod = sample_ff * rom_data;

   assign acc_sel = chan_ff ? acc_q_ff[tone_ff] : acc_i_ff[tone_ff];
   assign x_in    = (stage_ff == '0) ? DATA_W'(acc_sel) : x_ff;
   assign new_sum = sum_rdata + x_in - hist_rdata;

   always_comb begin
      ma_ctl.addr       = {tone_ff, chan_ff, stage_ff, hp_ff};
      ma_ctl.we         = (state_ff == S_FWR);
      ma_ctl.hist_wdata = x_in;
      ma_ctl.sum_wdata  = new_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_tones_ff  <= NUM_W'(16);
         first_step_ff <= '0;
         spacing_ff    <= '0;
         period_ff     <= 16'd4096;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_TONES:  num_tones_ff  <= csr_wdata[NUM_W-1:0];
            CSR_FIRST_STEP: first_step_ff <= csr_wdata;
            CSR_SPACING:    spacing_ff    <= csr_wdata;
            CSR_PERIOD:     period_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // load a new beat when emitting, drop the old one once it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         decim_ff     <= '0;
         hp_ff        <= '0;
         for (int t = 0; t < MAX_TONES; t++) begin
            acc_i_ff[t] <= '0;
            acc_q_ff[t] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  sample_ff <= req_sample;
                  nlast_ff  <= TONE_W'(n_eff - 1'b1);
                  tone_ff   <= '0;
                  step_ff   <= first_step_ff;
                  state_ff  <= S_PHASE;
               end
            end
            S_PHASE: begin
               phase_ff <= pos_ff * step_ff;
               state_ff <= S_SIN;
            end
            S_SIN: state_ff <= S_COS;
            S_COS: begin
               mul_ff   <= mix_prod;
               state_ff <= S_MQ;
            end
            S_MQ: begin
               acc_q_ff[tone_ff] <= acc_q_ff[tone_ff] - ACC_W'(mul_ff);
               mul_ff   <= mix_prod;
               state_ff <= S_MI;
            end
            S_MI: begin
               acc_i_ff[tone_ff] <= acc_i_ff[tone_ff] + ACC_W'(mul_ff);
               step_ff <= step_ff + spacing_ff;
               if (tone_ff != nlast_ff) begin
                  tone_ff  <= tone_ff + 1'b1;
                  state_ff <= S_PHASE;
               end else begin
                  if ({1'b0, pos_ff} + 17'd1 >= {1'b0, period_ff}) begin
                     pos_ff <= '0;
                  end else begin
                     pos_ff <= pos_ff + 1'b1;
                  end
                  if (32'(decim_ff) + 32'd1 < 32'(DECIM)) begin
                     decim_ff <= decim_ff + 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     decim_ff <= '0;
                     tone_ff  <= '0;
                     chan_ff  <= 1'b0;
                     stage_ff <= '0;
                     state_ff <= S_FRD;
                  end
               end
            end
            S_FRD: state_ff <= S_FWR;
            S_FWR: begin
               x_ff <= new_sum;
               if (32'(stage_ff) != STAGES - 1) begin
                  stage_ff <= stage_ff + 1'b1;
                  state_ff <= S_FRD;
               end else if (!chan_ff) begin
                  xi_ff    <= new_sum;
                  chan_ff  <= 1'b1;
                  stage_ff <= '0;
                  state_ff <= S_FRD;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit_go) begin
                  rsp_tone_ff  <= 4'(tone_ff);
                  rsp_i_ff     <= xi_ff;
                  rsp_q_ff     <= x_ff;
                  rsp_last_ff  <= (tone_ff == nlast_ff);
                  chan_ff      <= 1'b0;
                  stage_ff     <= '0;
                  if (tone_ff == nlast_ff) begin
                     // block done: clear every accumulator, advance history slot
                     for (int t = 0; t < MAX_TONES; t++) begin
                        acc_i_ff[t] <= '0;
                        acc_q_ff[t] <= '0;
                     end
                     if (32'(hp_ff) + 1 >= MA_LEN) begin
                        hp_ff <= '0;
                     end else begin
                        hp_ff <= hp_ff + 1'b1;
                     end
                     state_ff <= S_IDLE;
                  end else begin
                     tone_ff  <= tone_ff + 1'b1;
                     state_ff <= S_FRD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tone_index = rsp_tone_ff;
   assign rsp_baseband_i = rsp_i_ff;
   assign rsp_baseband_q = rsp_q_ff;
   assign rsp_last       = rsp_last_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result beat raised outside emit");

   a_last_is_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_tone_ff == 4'(nlast_ff)))
      else $error("last flag on wrong tone");

   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> (req_stall && !ma_ctl.we))
      else $error("activity during clearing pass");

   a_emit_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled result dropped");
endmodule
